FILE: rtl/cau_pkg.sv
`timescale 1ns / 1ps

package cau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    localparam int AS_BITS   = WORD_BITS + 1;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int DEN_BITS  = PROD_BITS;
    localparam int REM_BITS  = PROD_BITS + 1;
    localparam int QUO_BITS  = WORD_BITS + 1;
    localparam int SCL_BITS  = SUM_BITS + FRAC_BITS;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef struct packed {
        logic                neg;
        logic                big;
        logic [REM_BITS-1:0] rem;
        logic [QUO_BITS-1:0] sh;
    } part_t;

    typedef struct packed {
        logic                vld;
        logic                is_div;
        logic                dz;
        logic [DEN_BITS-1:0] den;
        part_t               re;
        part_t               im;
    } lane_t;

endpackage

FILE: rtl/cau_div_stage.sv
`timescale 1ns / 1ps

module cau_div_stage
    import cau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  lane_t d,
    output lane_t q
);

    lane_t q_reg;
    lane_t q_next;

    function automatic part_t div_step(part_t p, logic [DEN_BITS-1:0] den);
        part_t               r;
        logic [REM_BITS-1:0] t;
        logic                ge;
        r  = p;
        t  = {p.rem[REM_BITS-2:0], p.sh[QUO_BITS-1]};
        ge = (t >= REM_BITS'(den));
        r.rem = ge ? (t - REM_BITS'(den)) : t;
        r.sh  = {p.sh[QUO_BITS-2:0], ge};
        return r;
    endfunction

    always_comb
    begin
        q_next = d;
        if (d.is_div)
        begin
            q_next.re = div_step(d.re, d.den);
            q_next.im = div_step(d.im, d.den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: rtl/complex_arith_unit_top.sv
`timescale 1ns / 1ps

// Complex add, subtract, multiply and divide on signed Q16.16 operands. A request is taken in
// every cycle and busy stays low. Every request gives one result, marked by done. The result
// passes through registers in this order: the six multipliers, the product sums, the divide
// preparation, a chain of register stages for the quotient bits in the two restoring dividers,
// and saturation. All operations pass through the same registers, so results leave in
// request order.

module complex_arith_unit_top
    import cau_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  func,
    input  logic signed [WORD_BITS-1:0] a_real,
    input  logic signed [WORD_BITS-1:0] a_imag,
    input  logic signed [WORD_BITS-1:0] b_real,
    input  logic signed [WORD_BITS-1:0] b_imag,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] res_real,
    output logic signed [WORD_BITS-1:0] res_imag,
    output logic                        overflow,
    output logic                        div_zero
);

    logic                        v1_reg;
    func_t                       func1_reg;
    logic signed [PROD_BITS-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, q_rr_reg, q_ii_reg;
    logic signed [AS_BITS-1:0]   as_re_reg, as_im_reg;
    logic signed [AS_BITS-1:0]   as_re_next, as_im_next;

    logic                        v2_reg;
    func_t                       func2_reg;
    logic signed [SUM_BITS-1:0]  s_re_reg, s_im_reg, s_re_next, s_im_next;
    logic [DEN_BITS-1:0]         den_reg, den_next;

    lane_t                       chain [0:QUO_BITS];
    lane_t                       prep_reg, prep_next;

    logic                        done_reg;
    logic [WORD_BITS-1:0]        res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic                        ov_reg, dz_reg, ov_re, ov_im;

    function automatic part_t prep_part(logic signed [SUM_BITS-1:0] s, func_t f,
                                        logic [DEN_BITS-1:0] den);
        part_t               p;
        logic [SUM_BITS-1:0] mag;
        logic [SUM_BITS-1:0] m;
        logic [SCL_BITS-1:0] scl;
        p.neg = s[SUM_BITS-1];
        mag   = p.neg ? (~s + 1'b1) : s;
        m     = (f == FUNC_MUL) ? (mag >> FRAC_BITS) : mag;
        scl   = SCL_BITS'(mag) << FRAC_BITS;
        if (f == FUNC_DIV)
        begin
            p.rem = REM_BITS'(scl >> QUO_BITS);
            p.sh  = scl[QUO_BITS-1:0];
            p.big = (p.rem >= REM_BITS'(den));
        end
        else
        begin
            p.rem = '0;
            p.sh  = m[QUO_BITS-1:0];
            p.big = |(m >> QUO_BITS);
        end
        return p;
    endfunction

    function automatic logic [WORD_BITS:0] sat_part(part_t p);
        logic [QUO_BITS-1:0] lim;
        logic [QUO_BITS-1:0] v;
        logic                ov;
        lim = QUO_BITS'(1) << (WORD_BITS - 1);
        if (!p.neg)
        begin
            lim = lim - 1'b1;
        end
        ov = p.big || (p.sh > lim);
        v  = ov ? lim : p.sh;
        v  = p.neg ? (QUO_BITS'(0) - v) : v;
        return {ov, v[WORD_BITS-1:0]};
    endfunction

    assign busy = 1'b0;

    always_comb
    begin
        if (func_t'(func) == FUNC_SUB)
        begin
            as_re_next = AS_BITS'(a_real) - AS_BITS'(b_real);
            as_im_next = AS_BITS'(a_imag) - AS_BITS'(b_imag);
        end
        else
        begin
            as_re_next = AS_BITS'(a_real) + AS_BITS'(b_real);
            as_im_next = AS_BITS'(a_imag) + AS_BITS'(b_imag);
        end
    end

    always_comb
    begin
        den_next = DEN_BITS'($unsigned(q_rr_reg)) + DEN_BITS'($unsigned(q_ii_reg));
        unique case (func1_reg)
            FUNC_ADD, FUNC_SUB:
            begin
                s_re_next = SUM_BITS'(as_re_reg);
                s_im_next = SUM_BITS'(as_im_reg);
            end
            FUNC_MUL:
            begin
                s_re_next = SUM_BITS'(p_rr_reg) - SUM_BITS'(p_ii_reg);
                s_im_next = SUM_BITS'(p_ir_reg) + SUM_BITS'(p_ri_reg);
            end
            FUNC_DIV:
            begin
                s_re_next = SUM_BITS'(p_rr_reg) + SUM_BITS'(p_ii_reg);
                s_im_next = SUM_BITS'(p_ir_reg) - SUM_BITS'(p_ri_reg);
            end
            default:
            begin
                s_re_next = '0;
                s_im_next = '0;
            end
        endcase
    end

    always_comb
    begin
        prep_next.vld    = v2_reg;
        prep_next.den    = den_reg;
        prep_next.dz     = (func2_reg == FUNC_DIV) && (den_reg == '0);
        prep_next.is_div = (func2_reg == FUNC_DIV) && !prep_next.dz;
        prep_next.re     = prep_part(s_re_reg, func2_reg, den_reg);
        prep_next.im     = prep_part(s_im_reg, func2_reg, den_reg);
        if (prep_next.dz)
        begin
            prep_next.re = '0;
            prep_next.im = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            prep_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            prep_reg <= prep_next;
            done_reg <= chain[QUO_BITS].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        func1_reg       <= func_t'(func);
        p_rr_reg        <= PROD_BITS'(a_real) * PROD_BITS'(b_real);
        p_ii_reg        <= PROD_BITS'(a_imag) * PROD_BITS'(b_imag);
        p_ir_reg        <= PROD_BITS'(a_imag) * PROD_BITS'(b_real);
        p_ri_reg        <= PROD_BITS'(a_real) * PROD_BITS'(b_imag);
        q_rr_reg        <= PROD_BITS'(b_real) * PROD_BITS'(b_real);
        q_ii_reg        <= PROD_BITS'(b_imag) * PROD_BITS'(b_imag);
        as_re_reg       <= as_re_next;
        as_im_reg       <= as_im_next;
        func2_reg       <= func1_reg;
        s_re_reg        <= s_re_next;
        s_im_reg        <= s_im_next;
        den_reg         <= den_next;
        res_re_reg      <= res_re_next;
        res_im_reg      <= res_im_next;
        ov_reg          <= ov_re | ov_im;
        dz_reg          <= chain[QUO_BITS].dz;
    end

    assign chain[0] = prep_reg;

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_div
        cau_div_stage u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .d     (chain[i]),
            .q     (chain[i+1])
        );
    end

    assign {ov_re, res_re_next} = sat_part(chain[QUO_BITS].re);
    assign {ov_im, res_im_next} = sat_part(chain[QUO_BITS].im);

    assign done     = done_reg;
    assign res_real = res_re_reg;
    assign res_imag = res_im_reg;
    assign overflow = ov_reg;
    assign div_zero = dz_reg;

endmodule
